@@ rtl/dar_pkg.sv @@
// dar_pkg: shared constants, types and the answer byte table for the
// DNS A-record responder. No dependencies.
package dar_pkg;

  localparam int MAX_PACKET_BYTES = 512;
  localparam int POS_W            = $clog2(MAX_PACKET_BYTES);
  localparam int ANSWER_BYTES     = 16;
  localparam int IDX_W            = $clog2(ANSWER_BYTES + 1);

  // question end + answer must fit: fail when pos + 1 + 16 > max
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PACKET_BYTES - ANSWER_BYTES - 1);

  localparam logic [POS_W-1:0] HDR_ID_HI = POS_W'(0);
  localparam logic [POS_W-1:0] HDR_ID_LO = POS_W'(1);
  localparam logic [POS_W-1:0] HDR_FLAGS = POS_W'(2);
  localparam logic [POS_W-1:0] HDR_QD_HI = POS_W'(4);
  localparam logic [POS_W-1:0] HDR_QD_LO = POS_W'(5);
  localparam logic [POS_W-1:0] HDR_AN_LO = POS_W'(7);
  localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(11);

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ANSWER_BYTES);

  localparam logic [7:0] FLAGS_QR    = 8'h80;
  localparam logic [7:0] LABEL_LIMIT = 8'd63;
  localparam logic [2:0] TAIL_BYTES  = 3'd4;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LABLEN = 5'b00010,
    PH_LABEL  = 5'b00100,
    PH_TAIL   = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    EMIT_NONE   = 2'd0,
    EMIT_ONE    = 2'd1,
    EMIT_ANSWER = 2'd2
  } emit_t;

  typedef struct packed {
    emit_t      kind;
    logic [7:0] data;
    logic       bad;
  } result_t;

  // answer record after the echoed last QCLASS byte (index 0)
  function automatic logic [7:0] answer_byte(input logic [IDX_W-1:0] idx,
                                             input logic [31:0] addr);
    logic [7:0] b;
    case (idx)
      IDX_W'(1):  b = 8'hc0;
      IDX_W'(2):  b = 8'h0c;
      IDX_W'(4):  b = 8'h01;
      IDX_W'(6):  b = 8'h01;
      IDX_W'(10): b = 8'd60;
      IDX_W'(12): b = 8'h04;
      IDX_W'(13): b = addr[31:24];
      IDX_W'(14): b = addr[23:16];
      IDX_W'(15): b = addr[15:8];
      IDX_W'(16): b = addr[7:0];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/dar_query_if.sv @@
// dar_query_if: query byte channel, valid/ready handshake.
// No dependencies.
interface dar_query_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_byte;
  logic       query_end;

  modport source (output valid, query_byte, query_end, input ready);
  modport sink   (input valid, query_byte, query_end, output ready);
endinterface

@@ rtl/dar_reply_if.sv @@
// dar_reply_if: reply byte channel, valid/ready handshake.
// No dependencies.
interface dar_reply_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_end;
  logic       reply_bad;

  modport source (output valid, reply_byte, reply_end, reply_bad, input ready);
  modport sink   (input valid, reply_byte, reply_end, reply_bad, output ready);
endinterface

@@ rtl/dar_parser.sv @@
// dar_parser: query parse state and per-word decision (header rewrite,
// label walk, QTYPE/QCLASS, error). Depends on dar_pkg.
module dar_parser
  import dar_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] qbyte,
  input  logic       qlast,
  output result_t    res
);

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [5:0]       lab, lab_next;
  logic             chn, chn_next;
  logic [2:0]       tail, tail_next;

  logic [2:0] tail_dec;
  logic [5:0] lab_dec;
  logic       err;
  logic       answer;
  logic       is_skip;

  assign tail_dec = tail - 3'd1;
  assign lab_dec  = lab - 6'd1;

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    lab_next   = lab;
    chn_next   = chn;
    tail_next  = tail;
    err        = 1'b0;
    answer     = 1'b0;
    is_skip    = 1'b0;
    res.kind   = EMIT_NONE;
    res.data   = qbyte;
    res.bad    = 1'b0;

    case (phase)
      PH_HEADER: begin
        case (pos)
          HDR_ID_HI, HDR_ID_LO: res.data = qbyte;
          HDR_FLAGS: res.data = FLAGS_QR | {7'd0, qbyte[0]};
          HDR_QD_HI: begin
            chn_next = (qbyte != 8'd0);
            res.data = 8'h00;
          end
          HDR_QD_LO: begin
            err      = !chn && (qbyte == 8'd0);
            res.data = 8'h01;
          end
          HDR_AN_LO: res.data = 8'h01;
          default:   res.data = 8'h00;
        endcase
        if (pos >= HDR_LAST) begin
          phase_next = PH_LABLEN;
        end
      end
      PH_LABLEN: begin
        if (qbyte > LABEL_LIMIT) begin
          err = 1'b1;
        end else if (qbyte == 8'd0) begin
          phase_next = PH_TAIL;
          tail_next  = TAIL_BYTES;
        end else begin
          phase_next = PH_LABEL;
          lab_next   = qbyte[5:0];
        end
      end
      PH_LABEL: begin
        lab_next = lab_dec;
        if (lab_dec == 6'd0) begin
          phase_next = PH_LABLEN;
        end
      end
      PH_TAIL: begin
        tail_next = tail_dec;
        answer    = (tail_dec == 3'd0);
      end
      default: is_skip = 1'b1;
    endcase

    if (!is_skip && pos > POS_LIMIT) begin
      err    = 1'b1;
      answer = 1'b0;
    end

    if (is_skip) begin
      res.kind = EMIT_NONE;
    end else if (answer) begin
      res.kind   = EMIT_ANSWER;
      res.data   = qbyte;
      phase_next = PH_SKIP;
    end else if (err || qlast) begin
      res.kind   = EMIT_ONE;
      res.data   = 8'h00;
      res.bad    = 1'b1;
      phase_next = PH_SKIP;
    end else begin
      res.kind = EMIT_ONE;
      pos_next = pos + POS_W'(1);
    end

    // end of packet: start clean
    if (qlast && (is_skip || answer || err || res.bad)) begin
      phase_next = PH_HEADER;
      pos_next   = '0;
      lab_next   = '0;
      chn_next   = 1'b0;
      tail_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      pos   <= '0;
      lab   <= '0;
      chn   <= 1'b0;
      tail  <= '0;
    end else if (step) begin
      phase <= phase_next;
      pos   <= pos_next;
      lab   <= lab_next;
      chn   <= chn_next;
      tail  <= tail_next;
    end
  end

endmodule

@@ rtl/dar_emitter.sv @@
// dar_emitter: reply register and 16-byte answer burst sequencer.
// Depends on dar_pkg and dar_reply_if.
module dar_emitter
  import dar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  input  logic [31:0] addr,
  output logic        can_load,
  dar_reply_if.source reply
);

  logic             out_valid;
  logic [7:0]       head;
  logic             bad;
  logic             answer;
  logic [IDX_W-1:0] idx;
  logic             last_word;
  logic             take;

  assign last_word = !answer || (idx == IDX_LAST);
  assign take      = out_valid && reply.ready;
  assign can_load  = !out_valid || (reply.ready && last_word);

  assign reply.valid      = out_valid;
  assign reply.reply_byte = (idx == '0) ? head : answer_byte(idx, addr);
  assign reply.reply_end  = answer ? (idx == IDX_LAST) : bad;
  assign reply.reply_bad  = !answer && bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      answer    <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      answer    <= (res.kind == EMIT_ANSWER);
      idx       <= '0;
    end else if (take) begin
      if (last_word) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // single words carry end only when they are error terminators
  always_ff @(posedge clk) begin
    if (load) begin
      head <= res.data;
      bad  <= res.bad;
    end
  end

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("reply word overwritten");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && answer |-> idx <= IDX_LAST)
    else $error("answer index out of range");
  a_burst_step: assert property (@(posedge clk) disable iff (rst)
    take && !last_word |=> out_valid && idx == $past(idx) + IDX_W'(1))
    else $error("answer burst skipped a word");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    take && last_word && !load |=> !out_valid)
    else $error("reply word repeated");
`endif

endmodule

@@ rtl/dns_a_record_responder_unit.sv @@
// dns_a_record_responder_unit: top level; input word register, answer
// address register, parser and reply emitter.
// Depends on dar_pkg, dar_query_if, dar_reply_if, dar_parser, dar_emitter.
// Path: an accepted query word passes through the input word register, then the reply register.
// Throughput: one query word per cycle unless reply back-pressure stalls it; a word
// that emits waits at the input while the answer burst drains through the reply register.
// Reset (rst, synchronous): parser to header phase, address 0; no clearing pass.
module dns_a_record_responder_unit
  import dar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  dar_query_if.sink   query,
  dar_reply_if.source reply
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_end;
  logic [31:0] answer_address;
  result_t     res;
  logic        can_load;
  logic        advance;

  assign advance     = s1_valid && ((res.kind == EMIT_NONE) || can_load);
  assign query.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (query.ready) begin
      s1_valid <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (query.ready && query.valid) begin
      s1_byte <= query.query_byte;
      s1_end  <= query.query_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= '0;
    end else if (cfg_we) begin
      answer_address <= cfg_data;
    end
  end

  dar_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .qbyte (s1_byte),
    .qlast (s1_end),
    .res   (res)
  );

  dar_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && (res.kind != EMIT_NONE)),
    .res      (res),
    .addr     (answer_address),
    .can_load (can_load),
    .reply    (reply)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for dns_a_record_responder_unit.
// Directed query rows, then random queries checked against an in-bench answer predictor.
// Depends on dar_pkg, dar_query_if, dar_reply_if and the responder RTL.
module tb_top;
  import dar_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       bad;
  } reply_word_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        e;
    logic        typed;
    reply_word_t want;
  } opening_row_t;

  // answer record after the echoed QCLASS byte, address excluded
  localparam logic [95:0] ANSWER_HEAD = 96'hc00c_0001_0001_0000_003c_0004;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [31:0] cfg_data;

  dar_query_if query_ch();
  dar_reply_if reply_ch();

  dns_a_record_responder_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .query    (query_ch),
    .reply    (reply_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // answer predictor state
  logic [9:0]  pkt_pos;
  phase_t      parse_ph;
  logic [5:0]  label_left;
  logic        qd_hi_set;
  logic [2:0]  tail_left;
  logic [31:0] answer_addr;

  reply_word_t fresh[$];
  reply_word_t replies_due[$];
  logic [7:0]  pkt[$];
  int          len_pos[$];
  opening_row_t opening [0:24];

  int mismatches;
  bit hold_off;
  bit calm;

  function automatic void push_reply(logic [7:0] d, logic f, logic bad);
    reply_word_t w;
    w.data = d;
    w.fin  = f;
    w.bad  = bad;
    fresh.push_back(w);
  endfunction

  function automatic void restart_packet();
    pkt_pos    = '0;
    parse_ph   = PH_HEADER;
    label_left = '0;
    qd_hi_set  = 1'b0;
    tail_left  = '0;
  endfunction

  function automatic void reject_packet(logic e);
    push_reply(8'h00, 1'b1, 1'b1);
    if (e) restart_packet();
    else parse_ph = PH_SKIP;
  endfunction

  function automatic void respond_to_byte(logic [7:0] b, logic e);
    logic [7:0] ob;
    ob = b;
    if (parse_ph == PH_SKIP) begin
      if (e) restart_packet();
      return;
    end
    if (int'(pkt_pos) + 1 + ANSWER_BYTES > MAX_PACKET_BYTES) begin
      reject_packet(e);
      return;
    end
    case (parse_ph)
      PH_HEADER: begin
        case (pkt_pos)
          HDR_ID_HI, HDR_ID_LO: ob = b;
          HDR_FLAGS: ob = FLAGS_QR | {7'd0, b[0]};
          HDR_QD_HI: begin
            qd_hi_set = (b != 8'h00);
            ob = 8'h00;
          end
          HDR_QD_LO: begin
            if (!qd_hi_set && b == 8'h00) begin
              reject_packet(e);
              return;
            end
            ob = 8'h01;
          end
          HDR_AN_LO: ob = 8'h01;
          default: ob = 8'h00;
        endcase
        if (pkt_pos >= HDR_LAST) parse_ph = PH_LABLEN;
      end
      PH_LABLEN: begin
        if (b > LABEL_LIMIT) begin
          reject_packet(e);
          return;
        end
        if (b == 8'h00) begin
          parse_ph  = PH_TAIL;
          tail_left = TAIL_BYTES;
        end else begin
          parse_ph   = PH_LABEL;
          label_left = b[5:0];
        end
      end
      PH_LABEL: begin
        label_left = label_left - 6'd1;
        if (label_left == 6'd0) parse_ph = PH_LABLEN;
      end
      default: begin
        tail_left = tail_left - 3'd1;
        if (tail_left == 3'd0) begin
          push_reply(b, 1'b0, 1'b0);
          for (int k = 0; k < 12; k++) push_reply(ANSWER_HEAD[95-8*k -: 8], 1'b0, 1'b0);
          push_reply(answer_addr[31:24], 1'b0, 1'b0);
          push_reply(answer_addr[23:16], 1'b0, 1'b0);
          push_reply(answer_addr[15:8], 1'b0, 1'b0);
          push_reply(answer_addr[7:0], 1'b1, 1'b0);
          if (e) restart_packet();
          else parse_ph = PH_SKIP;
          return;
        end
      end
    endcase
    if (e) begin
      reject_packet(1'b1);
      return;
    end
    pkt_pos = pkt_pos + 10'd1;
    push_reply(ob, 1'b0, 1'b0);
  endfunction

  function automatic void add_label(int len);
    len_pos.push_back(pkt.size());
    pkt.push_back(8'(len));
    repeat (len) pkt.push_back(8'($urandom));
  endfunction

  // well-formed query; last_len >= 0 builds a long name ending in a label of that length
  function automatic void build_query(int last_len);
    int n;
    pkt.delete();
    len_pos.delete();
    repeat (12) pkt.push_back(8'($urandom));
    if (pkt[4] == 8'h00 && pkt[5] == 8'h00) begin
      pkt[5] = 8'h01;
    end else if ($urandom_range(0, 5) == 0) begin
      pkt[4] = 8'($urandom_range(1, 255));
      pkt[5] = 8'h00;
    end
    if (last_len >= 0) begin
      repeat (7) add_label(63);
      add_label(last_len);
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) add_label(($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 8));
    end
    len_pos.push_back(pkt.size());
    pkt.push_back(8'h00);
    repeat (4) pkt.push_back(8'($urandom));
  endfunction

  task automatic send_word(input logic [7:0] b, input logic e, input logic typed,
                           input reply_word_t want);
    if (!calm && $urandom_range(0, 7) == 0) begin
      query_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    query_ch.valid      <= 1'b1;
    query_ch.query_byte <= b;
    query_ch.query_end  <= e;
    do @(posedge clk); while (!query_ch.ready);
    fresh.delete();
    respond_to_byte(b, e);
    if (typed) replies_due.push_back(want);
    else foreach (fresh[i]) replies_due.push_back(fresh[i]);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1, 1'b0, '0);
  endtask

  task automatic send_random_packet(output int n_words);
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    build_query(-1);
    if (pick < 15) begin
      repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
    end else if (pick < 23) begin
      pkt[4] = 8'h00;
      pkt[5] = 8'h00;
    end else if (pick < 33) begin
      pkt[len_pos[$urandom_range(0, len_pos.size() - 1)]] = 8'($urandom_range(8'h40, 8'hff));
    end else if (pick < 45) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end else if (pick < 57) begin
      pkt.delete();
      repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
    end
    send_packet();
    n_words = pkt.size();
  endtask

  task automatic drain_replies();
    query_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_address(input logic [31:0] a);
    drain_replies();
    cfg_we   <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    answer_addr = a;
    cfg_we <= 1'b0;
  endtask

  // reply checker
  always @(posedge clk) begin
    reply_word_t got;
    reply_word_t want;
    if (!rst && reply_ch.valid && reply_ch.ready) begin
      got.data = reply_ch.reply_byte;
      got.fin  = reply_ch.reply_end;
      got.bad  = reply_ch.reply_bad;
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply word, actual %02h end %b bad %b",
                 $time, got.data, got.fin, got.bad);
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: reply mismatch, expected %02h end %b bad %b, actual %02h end %b bad %b",
                   $time, want.data, want.fin, want.bad, got.data, got.fin, got.bad);
        end
      end
    end
  end

  // reply side back-pressure
  initial begin
    reply_ch.ready <= 1'b0;
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        reply_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        reply_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        reply_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    logic [31:0] phase_addr [4];
    int random_words;
    int n;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_data            <= '0;
    query_ch.valid      <= 1'b0;
    query_ch.query_byte <= '0;
    query_ch.query_end  <= 1'b0;
    mismatches   = 0;
    hold_off     = 1'b0;
    calm         = 1'b0;
    answer_addr  = '0;
    random_words = 0;
    restart_packet();
    // query with extreme header bytes and a one-byte label, then a header cut short
    // by an end mark on the low question count byte
    opening = '{
      '{8'hff, 1'b0, 1'b1, '{8'hff, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'hff, 1'b0, 1'b1, '{8'h81, 1'b0, 1'b0}},
      '{8'hff, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h01, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b0}},
      '{8'hff, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b0}},
      '{8'haa, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h55, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'hff, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h01, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b0}},
      '{8'hff, 1'b0, 1'b1, '{8'hff, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h01, 1'b0, 1'b1, '{8'h01, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'hff, 1'b1, 1'b0, '0},
      '{8'h12, 1'b0, 1'b1, '{8'h12, 1'b0, 1'b0}},
      '{8'h34, 1'b0, 1'b1, '{8'h34, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h80, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}
    };
    phase_addr[0] = 32'hffff_ffff;
    phase_addr[1] = 32'h0000_0000;
    phase_addr[2] = $urandom;
    phase_addr[3] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_word(opening[i].b, opening[i].e, opening[i].typed, opening[i].want);

    for (int p = 0; p < 4; p++) begin
      if (p == 3) calm = 1'b1;
      write_address(phase_addr[p]);
      if (p == 1) hold_off = 1'b1;
      while (random_words < 72 * (p + 1)) begin
        send_random_packet(n);
        random_words += n;
      end
    end

    query_ch.valid <= 1'b0;
    for (int i = 0; i < 20000 && replies_due.size() != 0; i++) @(posedge clk);
    if (replies_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d reply words never arrived", $time, replies_due.size());
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
